[sv/hbd_pkg.sv]
// Shared types, codes and helpers of the HTTP body dechunker.
`default_nettype none

package hbd_pkg;

   localparam int LINE_MAX_DEFAULT    = 128;
   localparam int COUNT_WIDTH_DEFAULT = 48;
   localparam int LIMIT_WIDTH         = 48;
   localparam int CSR_INDEX_WIDTH     = 1;
   localparam int CSR_DATA_WIDTH      = LIMIT_WIDTH;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_BODY_MODE    = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_LENGTH_LIMIT = 1'b1;

   // body modes
   localparam logic [1:0] MODE_NO_BODY     = 2'd0;
   localparam logic [1:0] MODE_LENGTH      = 2'd1;
   localparam logic [1:0] MODE_UNTIL_CLOSE = 2'd2;
   localparam logic [1:0] MODE_CHUNKED     = 2'd3;

   // status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_EARLY_EOF = 2'd1;
   localparam logic [1:0] STATUS_LONG_LINE = 2'd2;

   localparam logic [7:0] CHAR_LF = 8'h0A;
   localparam logic [7:0] CHAR_CR = 8'h0D;

   typedef struct packed {
      logic [7:0] data_in;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [7:0] data_out;
      logic       data_valid;
      logic       body_done;
      logic [1:0] status;
   } rsp_type;

   typedef struct packed {
      logic                       wen;
      logic [CSR_INDEX_WIDTH-1:0] index;
      logic [CSR_DATA_WIDTH-1:0]  wdata;
   } csr_type;

   // Hex digit decode: bit 4 flags a hex digit, bits 3:0 carry its value.
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[sv/http_body_dechunker.sv]
// Top level of the HTTP message body decoder: handshakes and result register.
//
//   channel  | ports                              | direction | payload
//   ---------+------------------------------------+-----------+--------------------
//   request  | req_valid, req_stall, req_data     | in        | raw byte or close
//   response | rsp_valid, rsp_stall, rsp_data     | out       | byte, done, status
//   config   | csr_wen, csr_index, csr_wdata      | in        | body_mode, length_limit
//
// One request word per clock while req_stall is low; its response word sits in the
// result register in the cycle after acceptance. The decode state and the result
// register are the only storage on the path, so throughput is one word per cycle unless stalled.
// req_stall rises only while a response is held and rsp_stall is high.
// Reset is synchronous, active high: no body, unlimited length, body done.
// A config write restarts the decoder for a new body from the next cycle.
`default_nettype none

module http_body_dechunker #(
   parameter int LINE_MAX    = hbd_pkg::LINE_MAX_DEFAULT,
   parameter int COUNT_WIDTH = hbd_pkg::COUNT_WIDTH_DEFAULT
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  hbd_pkg::req_type                      req_data,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output hbd_pkg::rsp_type                      rsp_data,
   input  wire                                   csr_wen,
   input  wire [hbd_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  wire [hbd_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata
);

   hbd_pkg::csr_type csr;
   hbd_pkg::rsp_type rsp_next;
   hbd_pkg::rsp_type rsp_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             accept;

   assign csr.wen   = csr_wen;
   assign csr.index = csr_index;
   assign csr.wdata = csr_wdata;

   // hold the request side only while a finished word waits downstream
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   hbd_decoder #(
      .LINE_MAX    (LINE_MAX),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_decoder (
      .clock    (clock),
      .reset    (reset),
      .csr      (csr),
      .step     (accept),
      .req      (req_data),
      .rsp_next (rsp_next)
   );

   // advance the result register on accept; drop valid once the word is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // every accepted word yields a response word in the next cycle
   a_accept_gives_rsp : assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted word produced no response");

   // payload bytes only flow while the body is healthy
   a_data_ok : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.data_valid) |-> (rsp_data.status == hbd_pkg::STATUS_OK))
      else $error("payload byte passed with error status");

   // a normal end never coexists with an error
   a_done_ok : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.body_done) |-> (rsp_data.status == hbd_pkg::STATUS_OK))
      else $error("body done reported together with an error");

   // non-payload words carry a zero byte
   a_idle_byte : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.data_valid) |-> (rsp_data.data_out == 8'd0))
      else $error("data_out not zero without data_valid");

endmodule

`default_nettype wire

[sv/hbd_decoder.sv]
// Body decode state, configuration registers and per-word update logic.
`default_nettype none

module hbd_decoder #(
   parameter int LINE_MAX    = hbd_pkg::LINE_MAX_DEFAULT,
   parameter int COUNT_WIDTH = hbd_pkg::COUNT_WIDTH_DEFAULT
) (
   input  wire              clock,
   input  wire              reset,
   input  hbd_pkg::csr_type csr,
   input  wire              step,
   input  hbd_pkg::req_type req,
   output hbd_pkg::rsp_type rsp_next
);

   localparam int LCW = $clog2(LINE_MAX);
   localparam int XW  = (COUNT_WIDTH > hbd_pkg::LIMIT_WIDTH) ? COUNT_WIDTH
                                                             : hbd_pkg::LIMIT_WIDTH;
   localparam logic [LCW-1:0] LINE_LAST = LCW'(LINE_MAX - 1);
   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

   typedef enum logic [2:0] {
      ST_SIZE,
      ST_DATA,
      ST_DATA_END,
      ST_TRAILER,
      ST_DONE
   } state_type;

   state_type                          state_ff, state_in;
   logic [1:0]                         mode_ff, mode_in;
   logic [hbd_pkg::LIMIT_WIDTH-1:0]    limit_ff, limit_in;
   logic [COUNT_WIDTH-1:0]             rem_ff, rem_in;
   logic [LCW-1:0]                     line_ff, line_in;
   logic                               hex_stop_ff, hex_stop_in;
   logic                               prev_cr_ff, prev_cr_in;
   logic                               finished_ff, finished_in;
   logic [1:0]                         fail_ff, fail_in;

   logic                               limited;
   logic                               new_limited;
   logic                               new_lenmode;
   logic [XW-1:0]                      lim_ext;
   logic [COUNT_WIDTH-1:0]             start_rem;
   logic [4:0]                         hex;
   logic [7:0]                         c;

   assign c       = req.data_in;
   assign hex     = hbd_pkg::hex_decode(c);
   assign limited = ~limit_ff[hbd_pkg::LIMIT_WIDTH-1];

   always_comb begin
      mode_in     = mode_ff;
      limit_in    = limit_ff;
      state_in    = state_ff;
      rem_in      = rem_ff;
      line_in     = line_ff;
      hex_stop_in = hex_stop_ff;
      prev_cr_in  = prev_cr_ff;
      finished_in = finished_ff;
      fail_in     = fail_ff;
      new_limited = 1'b0;
      new_lenmode = 1'b0;
      lim_ext     = '0;
      start_rem   = '0;
      rsp_next.data_out   = 8'd0;
      rsp_next.data_valid = 1'b0;

      if (csr.wen) begin
         // restart the body with the freshly written registers
         if (csr.index == hbd_pkg::REG_BODY_MODE) begin
            mode_in = csr.wdata[1:0];
         end else begin
            limit_in = csr.wdata;
         end
         new_limited = ~limit_in[hbd_pkg::LIMIT_WIDTH-1];
         new_lenmode = (mode_in == hbd_pkg::MODE_LENGTH) ||
                       (mode_in == hbd_pkg::MODE_UNTIL_CLOSE);
         lim_ext     = XW'(limit_in);
         if (lim_ext > XW'(CNT_MAX)) begin
            start_rem = CNT_MAX;
         end else begin
            start_rem = lim_ext[COUNT_WIDTH-1:0];
         end
         rem_in      = (new_lenmode && new_limited) ? start_rem : '0;
         line_in     = '0;
         hex_stop_in = 1'b0;
         prev_cr_in  = 1'b0;
         fail_in     = hbd_pkg::STATUS_OK;
         finished_in = (mode_in == hbd_pkg::MODE_NO_BODY) ||
                       (new_lenmode && new_limited && rem_in == '0);
         state_in    = finished_in ? ST_DONE : ST_SIZE;
      end else if (step && !finished_ff && fail_ff == hbd_pkg::STATUS_OK) begin
         if (req.end_of_input) begin
            if (mode_ff == hbd_pkg::MODE_UNTIL_CLOSE) begin
               finished_in = 1'b1;
               state_in    = ST_DONE;
            end else begin
               fail_in = hbd_pkg::STATUS_EARLY_EOF;
            end
         end else if (mode_ff == hbd_pkg::MODE_CHUNKED) begin
            case (state_ff)
               ST_SIZE: begin
                  if (c == hbd_pkg::CHAR_LF) begin
                     state_in    = (rem_ff != '0) ? ST_DATA : ST_TRAILER;
                     line_in     = '0;
                     hex_stop_in = 1'b0;
                     prev_cr_in  = 1'b0;
                  end else if (line_ff == LINE_LAST) begin
                     fail_in = hbd_pkg::STATUS_LONG_LINE;
                  end else begin
                     line_in = line_ff + 1'b1;
                     if (!hex_stop_ff) begin
                        if (!hex[4]) begin
                           hex_stop_in = 1'b1;
                        end else if (rem_ff[COUNT_WIDTH-1 -: 4] != 4'd0) begin
                           rem_in = CNT_MAX;
                        end else begin
                           rem_in = {rem_ff[COUNT_WIDTH-5:0], hex[3:0]};
                        end
                     end
                  end
               end
               ST_DATA: begin
                  rsp_next.data_out   = c;
                  rsp_next.data_valid = 1'b1;
                  rem_in = rem_ff - 1'b1;
                  if (rem_in == '0) begin
                     state_in    = ST_DATA_END;
                     line_in     = '0;
                     hex_stop_in = 1'b0;
                     prev_cr_in  = 1'b0;
                  end
               end
               ST_DATA_END: begin
                  if (c == hbd_pkg::CHAR_LF) begin
                     state_in    = ST_SIZE;
                     rem_in      = '0;
                     line_in     = '0;
                     hex_stop_in = 1'b0;
                     prev_cr_in  = 1'b0;
                  end else if (line_ff == LINE_LAST) begin
                     fail_in = hbd_pkg::STATUS_LONG_LINE;
                  end else begin
                     line_in = line_ff + 1'b1;
                  end
               end
               ST_TRAILER: begin
                  if (c == hbd_pkg::CHAR_LF) begin
                     // empty line (bare LF or CR LF) closes the trailers
                     if (line_ff == '0 || (line_ff == LCW'(1) && prev_cr_ff)) begin
                        state_in    = ST_DONE;
                        finished_in = 1'b1;
                     end
                     line_in     = '0;
                     hex_stop_in = 1'b0;
                     prev_cr_in  = 1'b0;
                  end else begin
                     if (line_ff < LCW'(2)) begin
                        line_in = line_ff + 1'b1;
                     end
                     prev_cr_in = (c == hbd_pkg::CHAR_CR);
                  end
               end
               default: begin
               end
            endcase
         end else begin
            rsp_next.data_out   = c;
            rsp_next.data_valid = 1'b1;
            if (limited) begin
               rem_in = rem_ff - 1'b1;
               if (rem_in == '0) begin
                  finished_in = 1'b1;
                  state_in    = ST_DONE;
               end
            end
         end
      end

      rsp_next.body_done = finished_in && (fail_in == hbd_pkg::STATUS_OK);
      rsp_next.status    = fail_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= hbd_pkg::MODE_NO_BODY;
         limit_ff    <= '1;
         state_ff    <= ST_DONE;
         rem_ff      <= '0;
         line_ff     <= '0;
         hex_stop_ff <= 1'b0;
         prev_cr_ff  <= 1'b0;
         finished_ff <= 1'b1;
         fail_ff     <= hbd_pkg::STATUS_OK;
      end else begin
         mode_ff     <= mode_in;
         limit_ff    <= limit_in;
         state_ff    <= state_in;
         rem_ff      <= rem_in;
         line_ff     <= line_in;
         hex_stop_ff <= hex_stop_in;
         prev_cr_ff  <= prev_cr_in;
         finished_ff <= finished_in;
         fail_ff     <= fail_in;
      end
   end

endmodule

`default_nettype wire

[bench/testbench.sv]
// Self-checking bench for the HTTP message body decoder: random stimulus, inline predictor.
`timescale 1ns / 100ps

module testbench;
   import hbd_pkg::*;

   // Decoder phases as the predictor tracks them.
   typedef enum logic [2:0] {
      AT_SIZE_LINE, IN_CHUNK_DATA, AT_DATA_END, IN_TRAILERS, BODY_OVER
   } dec_state_type;

   localparam int          LINE_LIMIT  = LINE_MAX_DEFAULT;
   localparam int          WORD_TARGET = 1150;   // live words before the random part stops
   localparam int          QUIET_MARK  = 1000;   // live words after which nobody idles
   localparam int          LONG_HOLD   = 150;    // receiver hold-off, in cycles
   localparam logic [47:0] SIZE_MAX    = '1;
   localparam logic [47:0] SHIFT_LIMIT = SIZE_MAX >> 4;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   req_type                    req_data = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   rsp_type                    rsp_data;
   logic                       csr_wen = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   http_body_dechunker i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Hard stop in case a word is lost or the handshake locks up.
   initial begin
      #4_000_000;
      $display("Some tests failed");
      $finish;
   end

   // ------------------------------------------------------------------
   // Decoder predictor: its own copy of the registers and body state.
   // ------------------------------------------------------------------
   logic [1:0]     cfg_mode;
   logic [47:0]    cfg_limit;
   dec_state_type  dec_state;
   logic [47:0]    bytes_left;
   int             line_len;
   bit             hex_done;
   bit             last_cr;
   bit             body_ended;
   bit             body_failed;
   logic [1:0]     fail_status;
   bit             length_bounded;
   int             live_words;

   // Restart for a new body; any register write does this.
   function automatic void restart_body();
      bit by_length;
      by_length      = (cfg_mode == MODE_LENGTH || cfg_mode == MODE_UNTIL_CLOSE);
      length_bounded = !cfg_limit[47];
      bytes_left     = (by_length && length_bounded) ? cfg_limit : '0;
      line_len       = 0;
      hex_done       = 1'b0;
      last_cr        = 1'b0;
      body_failed    = 1'b0;
      fail_status    = STATUS_OK;
      body_ended     = (cfg_mode == MODE_NO_BODY) ||
                       (by_length && length_bounded && bytes_left == '0);
      dec_state      = body_ended ? BODY_OVER : AT_SIZE_LINE;
   endfunction

   function automatic void clear_line();
      line_len = 0;
      hex_done = 1'b0;
      last_cr  = 1'b0;
   endfunction

   function automatic void end_body();
      body_ended = 1'b1;
      dec_state  = BODY_OVER;
   endfunction

   function automatic void flag_failure(logic [1:0] code);
      body_failed = 1'b1;
      fail_status = code;
   endfunction

   // Count one non-LF byte of a bounded line; true once the line is too long.
   function automatic bit count_line_byte();
      line_len++;
      if (line_len >= LINE_LIMIT) begin
         flag_failure(STATUS_LONG_LINE);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic int hex_digit(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - int'("0");
      if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
      if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
      return -1;
   endfunction

   // Advance the predictor by one request word and return the response it owes.
   function automatic rsp_type decode_word(req_type w);
      rsp_type r;
      int      digit;
      r = '0;
      if (!body_ended && !body_failed) begin
         live_words++;
         if (w.end_of_input) begin
            if (cfg_mode == MODE_UNTIL_CLOSE) end_body();
            else flag_failure(STATUS_EARLY_EOF);
         end else if (cfg_mode == MODE_CHUNKED) begin
            case (dec_state)
               AT_SIZE_LINE: begin
                  if (w.data_in == CHAR_LF) begin
                     dec_state = (bytes_left != '0) ? IN_CHUNK_DATA : IN_TRAILERS;
                     clear_line();
                  end else if (!count_line_byte() && !hex_done) begin
                     digit = hex_digit(w.data_in);
                     if (digit < 0) hex_done = 1'b1;
                     else if (bytes_left > SHIFT_LIMIT) bytes_left = SIZE_MAX;
                     else bytes_left = {bytes_left[43:0], 4'(digit)};
                  end
               end
               IN_CHUNK_DATA: begin
                  r.data_out   = w.data_in;
                  r.data_valid = 1'b1;
                  bytes_left--;
                  if (bytes_left == '0) begin
                     dec_state = AT_DATA_END;
                     clear_line();
                  end
               end
               AT_DATA_END: begin
                  if (w.data_in == CHAR_LF) begin
                     dec_state  = AT_SIZE_LINE;
                     bytes_left = '0;
                     clear_line();
                  end else begin
                     void'(count_line_byte());
                  end
               end
               IN_TRAILERS: begin
                  if (w.data_in == CHAR_LF) begin
                     // an empty line, bare or CR-terminated, closes the trailers
                     if (line_len == 0 || (line_len == 1 && last_cr)) end_body();
                     clear_line();
                  end else begin
                     if (line_len < 2) line_len++;
                     last_cr = (w.data_in == CHAR_CR);
                  end
               end
               default: ;
            endcase
         end else begin
            r.data_out   = w.data_in;
            r.data_valid = 1'b1;
            if (length_bounded) begin
               bytes_left--;
               if (bytes_left == '0) end_body();
            end
         end
      end
      r.body_done = body_ended && !body_failed;
      r.status    = fail_status;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Request side: pending words, expected responses, idling controls.
   // ------------------------------------------------------------------
   req_type word_queue[$];      // words waiting for the driver
   req_type draft[$];           // body under construction
   rsp_type expected_rsp[$];    // responses owed by the block, oldest first
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;
   int      send_gap = 0;
   int      recv_gap = 0;
   int      hold_left = 0;
   int      hold_req = 0;
   int      hold_ack = 0;
   int      fail_count = 0;
   int      words_checked = 0;
   int      payload_bytes = 0;
   int      bodies_done = 0;
   int      early_closes = 0;
   int      long_lines = 0;
   int      phase_count = 0;

   // Driver: present words from the queue, hold them while stalled, idle in bursts.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall) expected_rsp.push_back(decode_word(req_data));
         // free to change the word only when nothing is held
         if (!req_valid || !req_stall) begin
            if (send_gap == 0 && send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
               send_gap = $urandom_range(12, 1);
            if (send_gap != 0 || word_queue.size() == 0) begin
               if (send_gap != 0) send_gap--;
               req_valid <= 1'b0;
            end else begin
               req_valid <= 1'b1;
               req_data  <= word_queue.pop_front();
            end
         end
      end
   end

   function automatic void compare_field(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", field, want, got);
         fail_count++;
      end
   endfunction

   // Check one response word against the oldest expectation.
   function automatic void check_word(rsp_type got);
      rsp_type want;
      if (expected_rsp.size() == 0) begin
         $error("response word %0h arrived with nothing expected", got);
         fail_count++;
         return;
      end
      want = expected_rsp.pop_front();
      compare_field("data_out", want.data_out, got.data_out);
      compare_field("data_valid", want.data_valid, got.data_valid);
      compare_field("body_done", want.body_done, got.body_done);
      compare_field("status", want.status, got.status);
      words_checked++;
      if (got.data_valid) payload_bytes++;
   endfunction

   // Monitor: take responses, stall in random bursts, serve long hold-off requests.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         recv_gap  = 0;
         hold_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) check_word(rsp_data);
         if (hold_ack != hold_req) begin
            hold_ack  = hold_req;
            hold_left = LONG_HOLD;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (recv_gap != 0) begin
            recv_gap--;
            rsp_stall <= 1'b1;
         end else if (recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct) begin
            recv_gap = $urandom_range(12, 1) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers: build a body in the draft, then hand it over.
   // ------------------------------------------------------------------
   task automatic add_byte(logic [7:0] b);
      draft.push_back(req_type'({b, 1'b0}));
   endtask

   // Close mark; its data byte is don't-care, so randomize it.
   task automatic add_close();
      draft.push_back(req_type'({8'($urandom_range(255)), 1'b1}));
   endtask

   task automatic send_draft();
      word_queue = {word_queue, draft};
      draft.delete();
   endtask

   function automatic logic [7:0] text_byte();
      logic [7:0] b;
      b = 8'($urandom_range(255));
      if (b == CHAR_LF) b = ";";
      return b;
   endfunction

   function automatic logic [7:0] hex_char(int nibble);
      if (nibble < 10) return 8'("0" + nibble);
      return 8'(($urandom_range(1) ? "a" : "A") + nibble - 10);
   endfunction

   // CR is optional: a bare LF also ends a line.
   task automatic add_line_end();
      if ($urandom_range(3) != 0) add_byte(CHAR_CR);
      add_byte(CHAR_LF);
   endtask

   // Size line: optional leading zeros, hex digits in mixed case, optional extension.
   task automatic add_size_line(int size, int ext_len);
      int shift;
      repeat (($urandom_range(3) == 0) ? $urandom_range(2, 1) : 0) add_byte("0");
      shift = 28;
      while (shift > 0 && ((size >> shift) & 15) == 0) shift -= 4;
      while (shift >= 0) begin
         add_byte(hex_char((size >> shift) & 15));
         shift -= 4;
      end
      if (ext_len > 0) begin
         add_byte(";");
         repeat (ext_len - 1) add_byte(text_byte());
      end
      add_line_end();
   endtask

   task automatic add_data_end(int junk_len);
      repeat (junk_len) add_byte(text_byte());
      add_line_end();
   endtask

   // Trailer line: never starts with CR so that it cannot read as the empty line.
   task automatic add_trailer(int len);
      logic [7:0] first;
      first = text_byte();
      if (first == CHAR_CR) first = "X";
      add_byte(first);
      repeat (len - 1) add_byte(text_byte());
      add_line_end();
   endtask

   // Chunked body. stretch: 1 long size line, 2 long line after data, 3 long trailers.
   task automatic add_chunked_body(int stretch, int max_size);
      int chunks;
      int size;
      int k;
      chunks = $urandom_range(4, 1);
      for (k = 0; k < chunks; k++) begin
         size = $urandom_range(max_size, 1);
         add_size_line(size, (stretch == 1 && k == 0) ? $urandom_range(135, 120) :
                             ($urandom_range(4) == 0) ? $urandom_range(8, 1) : 0);
         repeat (size) add_byte(8'($urandom_range(255)));
         add_data_end((stretch == 2 && k == chunks - 1) ? $urandom_range(135, 120) :
                      ($urandom_range(7) == 0) ? $urandom_range(3, 1) : 0);
      end
      add_size_line(0, 0);
      repeat ($urandom_range(2))
         add_trailer((stretch == 3) ? $urandom_range(200, 120) : $urandom_range(12, 1));
      add_line_end();
   endtask

   function automatic logic [47:0] pick_limit();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         2:       return 48'h8000_0000_0000;
         3:       return 48'h7FFF_FFFF_FFFF;
         4:       return {1'b1, 15'($urandom), 32'($urandom)};
         5:       return {1'b0, 15'($urandom), 32'($urandom)};
         default: return 48'($urandom_range(30, 1));
      endcase
   endfunction

   // Register write at a clock edge; the predictor restarts along with the block.
   task automatic write_reg(logic [CSR_INDEX_WIDTH-1:0] idx, logic [CSR_DATA_WIDTH-1:0] value);
      @(posedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      if (idx == REG_BODY_MODE) cfg_mode = value[1:0];
      else cfg_limit = value;
      restart_body();
   endtask

   // Idle per phase; drop all idling near the end of the run.
   task automatic pick_idling();
      if (live_words >= QUIET_MARK) begin
         send_idle_pct <= 0;
         recv_idle_pct <= 0;
      end else begin
         send_idle_pct <= 15 * $urandom_range(2);
         recv_idle_pct <= 15 * $urandom_range(2);
      end
   endtask

   // Hand over the draft, wait for every response, then tally how the body ended.
   task automatic finish_phase();
      send_draft();
      do @(negedge clock);
      while (word_queue.size() != 0 || req_valid || expected_rsp.size() != 0);
      if (body_failed && fail_status == STATUS_EARLY_EOF) early_closes++;
      else if (body_failed) long_lines++;
      else if (body_ended) bodies_done++;
      phase_count++;
   endtask

   // ------------------------------------------------------------------
   // Test sequence.
   // ------------------------------------------------------------------
   initial begin
      int          scenario;
      int          n;
      int          keep;
      logic [1:0]  mode;
      logic [47:0] limit;

      cfg_mode   = MODE_NO_BODY;
      cfg_limit  = '1;
      live_words = 0;
      restart_body();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // No body after reset: everything is dropped, done from the start.
      add_byte("A");
      add_close();
      finish_phase();

      // Zero content length ends the body at once.
      write_reg(REG_BODY_MODE, MODE_LENGTH);
      write_reg(REG_LENGTH_LIMIT, '0);
      add_byte(8'hFF);
      finish_phase();

      // Count reached; the extra word is dropped.
      write_reg(REG_LENGTH_LIMIT, 48'd3);
      add_byte(8'h00);
      add_byte(8'hFF);
      add_byte(8'h5A);
      add_byte(8'h80);
      finish_phase();

      // Unlimited content length: the close counts as early.
      write_reg(REG_LENGTH_LIMIT, '1);
      add_byte(8'h01);
      add_byte(8'h7F);
      add_close();
      finish_phase();

      // Until close: the close ends the body normally.
      write_reg(REG_BODY_MODE, MODE_UNTIL_CLOSE);
      add_byte(CHAR_LF);
      add_close();
      finish_phase();

      // Until close with a limit: reaching it ends the body.
      write_reg(REG_LENGTH_LIMIT, 48'd2);
      add_byte(CHAR_CR);
      add_byte(" ");
      finish_phase();

      // Minimal chunked body: one byte, last chunk, empty trailer section.
      write_reg(REG_BODY_MODE, MODE_CHUNKED);
      add_byte("1"); add_byte(CHAR_CR); add_byte(CHAR_LF);
      add_byte("Z"); add_byte(CHAR_CR); add_byte(CHAR_LF);
      add_byte("0"); add_byte(CHAR_CR); add_byte(CHAR_LF);
      add_byte(CHAR_CR); add_byte(CHAR_LF);
      finish_phase();

      // Random bodies until enough words have reached a live decoder.
      while (live_words < WORD_TARGET) begin
         scenario = (phase_count == 7) ? -1 : $urandom_range(99);
         if (scenario < 0) begin
            // Hold off the receiver while a long body keeps coming: the block must fill.
            write_reg(REG_BODY_MODE, MODE_CHUNKED);
            send_idle_pct <= 0;
            recv_idle_pct <= 0;
            hold_req      <= hold_req + 1;
            add_chunked_body(0, 40);
         end else if (scenario < 72) begin
            if ($urandom_range(1)) write_reg(REG_LENGTH_LIMIT, pick_limit());
            write_reg(REG_BODY_MODE, MODE_CHUNKED);
            pick_idling();
            if (scenario < 55) begin
               add_chunked_body(0, ($urandom_range(5) == 0) ? 30 : 12);
               // words after the end are dropped
               repeat ($urandom_range(2)) add_byte(8'($urandom_range(255)));
               if ($urandom_range(3) == 0) add_close();
            end else if (scenario < 65) begin
               add_chunked_body($urandom_range(3, 1), 12);
            end else begin
               // truncated body: close anywhere inside it
               add_chunked_body(0, 12);
               keep = $urandom_range(draft.size() - 1);
               while (draft.size() > keep) void'(draft.pop_back());
               add_close();
            end
         end else if (scenario < 80) begin
            write_reg(REG_BODY_MODE, MODE_CHUNKED);
            pick_idling();
            if (scenario < 76) begin
               // oversized chunk size: may saturate, then the close comes early
               add_byte(hex_char($urandom_range(15, 1)));
               repeat ($urandom_range(19, 11)) add_byte(hex_char($urandom_range(15)));
               add_line_end();
               repeat ($urandom_range(10, 1)) add_byte(8'($urandom_range(255)));
               add_close();
            end else begin
               repeat ($urandom_range(40, 10)) add_byte(8'($urandom_range(255)));
               if ($urandom_range(1)) add_close();
            end
         end else if (scenario < 97) begin
            mode  = (scenario < 90) ? MODE_LENGTH : MODE_UNTIL_CLOSE;
            limit = pick_limit();
            if ($urandom_range(1)) begin
               write_reg(REG_BODY_MODE, mode);
               write_reg(REG_LENGTH_LIMIT, limit);
            end else begin
               write_reg(REG_LENGTH_LIMIT, limit);
               write_reg(REG_BODY_MODE, mode);
            end
            pick_idling();
            n = (!limit[47] && limit < 48'd40) ? $urandom_range(int'(limit) + 3)
                                                : $urandom_range(30);
            repeat (n) add_byte(8'($urandom_range(255)));
            if ($urandom_range(1)) add_close();
         end else begin
            write_reg(REG_BODY_MODE, MODE_NO_BODY);
            pick_idling();
            repeat ($urandom_range(3)) add_byte(8'($urandom_range(255)));
            if ($urandom_range(1)) add_close();
         end
         finish_phase();
      end

      // Let any stray response show up before the verdict.
      repeat (4) @(posedge clock);
      $display("Decoded %0d words over %0d bodies; %0d payload bytes passed through.",
               words_checked, phase_count, payload_bytes);
      $display("Bodies ended normally: %0d, by early close: %0d, by an overlong line: %0d.",
               bodies_done, early_closes, long_lines);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
